### src/vclos_pkg.sv
// ============================================================================
// vclos_pkg: shared types and constants
// Holds the item kinds, result causes, queue entry layout and the arctangent table.
// ============================================================================
package vclos_pkg;

    localparam int MAX_BOXES   = 64;
    localparam int SLOT_W      = 6;
    localparam int BOX_IDX_W   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CRD_W       = 24;
    localparam int CORDIC_STEPS = 22;
    localparam int FULL_ANGLE  = 46080;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_QUERY  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        CAUSE_SENSE   = 3'd0,
        CAUSE_FAR     = 3'd1,
        CAUSE_CONE    = 3'd2,
        CAUSE_BLOCKED = 3'd3,
        CAUSE_CLEAR   = 3'd4
    } cause_t;

    // One accepted item, as kept in the queue between front and back.
    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic signed [CRD_W-1:0] ax;
        logic signed [CRD_W-1:0] ay;
        logic signed [CRD_W-1:0] bx;
        logic signed [CRD_W-1:0] by;
        logic signed [CRD_W-1:0] vx;
        logic signed [CRD_W-1:0] vy;
        logic [22:0]       sr;
        logic [22:0]       vr;
        logic [15:0]       va;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQ,
        ST_DIST,
        ST_DOT,
        ST_ANG_PREP,
        ST_NORM,
        ST_CORDIC,
        ST_ANG_CMP,
        ST_BOX_RD,
        ST_BOX_A,
        ST_BOX_B,
        ST_BOX_C,
        ST_BOX_D,
        ST_DONE
    } bst_t;

    function automatic logic [22:0] atan_val(input logic [4:0] i);
        logic [22:0] r;
        begin
            unique case (i)
                5'd0:  r = 23'd2949120;
                5'd1:  r = 23'd1740967;
                5'd2:  r = 23'd919879;
                5'd3:  r = 23'd466945;
                5'd4:  r = 23'd234379;
                5'd5:  r = 23'd117304;
                5'd6:  r = 23'd58666;
                5'd7:  r = 23'd29335;
                5'd8:  r = 23'd14668;
                5'd9:  r = 23'd7334;
                5'd10: r = 23'd3667;
                5'd11: r = 23'd1833;
                5'd12: r = 23'd917;
                5'd13: r = 23'd458;
                5'd14: r = 23'd229;
                5'd15: r = 23'd115;
                5'd16: r = 23'd57;
                5'd17: r = 23'd29;
                5'd18: r = 23'd14;
                5'd19: r = 23'd7;
                5'd20: r = 23'd4;
                5'd21: r = 23'd2;
                default: r = 23'd0;
            endcase
            return r;
        end
    endfunction

endpackage

### src/vision_cone_line_of_sight_test.sv
// ============================================================================
// vision_cone_line_of_sight_test: line-of-sight check with vision cone
// Box table maintenance and target visibility queries over a stream interface.
// ============================================================================
// Usage:
// Items enter on the s_axis channel. tuser carries the kind (write box,
// remove box, clear all, query); tdata carries the slot and coordinates.
// Table updates produce no result. Each query produces exactly one transfer
// on the m_axis channel: tdata bit 0 is detected, bits 3:1 the cause.
// A query computes differences, squares and products and does the distance
// checks, normalizes the angle operands, runs the CORDIC iteration and the
// cone check, then takes each box slot through states BOX_RD to BOX_D,
// walking all MAX_BOXES slots through one shared slab-test unit and box
// memory read port. It stops at the first blocking box, and the DONE state
// raises the result valid. A query settled by the distance checks skips
// the angle and box steps. Table updates are applied at the back end.
// A two-entry queue sits between the input stage and the engine, so
// up to two items are accepted while the engine works or while the finished
// result waits. When the receiver stalls, the result is held in its output
// register and the engine stays idle until it is taken.
// Reset (aresetn low, synchronous) empties the queue, clears every box valid
// bit and drops any pending result.
// ============================================================================
module vision_cone_line_of_sight_test (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: slot[5:0], coord_a_x, coord_a_y, coord_b_x, coord_b_y, dir_x,
    // dir_y (24 each), sense_radius[22:0], vision_radius[22:0], vision_angle[15:0]
    input  logic [215:0] s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: detected[0], cause[3:1]
    output logic [7:0]   m_axis_tdata
);
    import vclos_pkg::*;

    item_t  in_item, q_item;
    logic   q_valid, q_ready;
    cause_t cause;

    // Unpack the input fields from the packed data word.
    always_comb begin
        in_item.kind = kind_t'(s_axis_tuser);
        in_item.slot = s_axis_tdata[5:0];
        in_item.ax   = s_axis_tdata[29:6];
        in_item.ay   = s_axis_tdata[53:30];
        in_item.bx   = s_axis_tdata[77:54];
        in_item.by   = s_axis_tdata[101:78];
        in_item.vx   = s_axis_tdata[125:102];
        in_item.vy   = s_axis_tdata[149:126];
        in_item.sr   = s_axis_tdata[172:150];
        in_item.vr   = s_axis_tdata[195:173];
        in_item.va   = s_axis_tdata[211:196];
    end

    vclos_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    vclos_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_cause (cause)
    );

    // Detected is true for the sense-radius case and for clear sight.
    assign m_axis_tdata = {4'b0, cause,
                           (cause == CAUSE_SENSE || cause == CAUSE_CLEAR)};

    // A result waiting on a stalled receiver keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A reported cause is always one of the defined codes.
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[3:1] <= CAUSE_CLEAR)
        else $error("cause out of range");

    // The detected flag agrees with the cause.
    a_det: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[0] ==
            (m_axis_tdata[3:1] == CAUSE_SENSE || m_axis_tdata[3:1] == CAUSE_CLEAR))
        else $error("detected flag inconsistent");

endmodule

### src/vclos_front.sv
// ============================================================================
// vclos_front: input stage and item queue
// Accepts items, keeps them in a short queue and hands them to the back part.
// ============================================================================
module vclos_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  vclos_pkg::item_t      in_item,
    output logic                  q_valid,
    input  logic                  q_ready,
    output vclos_pkg::item_t      q_item
);
    import vclos_pkg::*;

    // Two entries, addressed by one-bit pointers.
    item_t      mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_item;
        end
    end

endmodule

### src/vclos_back.sv
// ============================================================================
// vclos_back: table update and query engine
// Executes table writes and runs the distance, cone and box tests for queries.
// ============================================================================
module vclos_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  vclos_pkg::item_t     q_item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output vclos_pkg::cause_t    res_cause
);
    import vclos_pkg::*;

    bst_t state_reg, state_next;

    logic [MAX_BOXES-1:0] valid_reg;
    logic signed [CRD_W-1:0] mem_l [MAX_BOXES];
    logic signed [CRD_W-1:0] mem_t [MAX_BOXES];
    logic signed [CRD_W-1:0] mem_w [MAX_BOXES];
    logic signed [CRD_W-1:0] mem_h [MAX_BOXES];
    logic signed [CRD_W-1:0] rl_reg, rt_reg, rw_reg, rh_reg;

    item_t it_reg;
    logic signed [24:0] dx_reg, dy_reg;
    logic [49:0] dx2_reg, dy2_reg;
    logic [45:0] sr2_reg, vr2_reg;
    logic signed [50:0] dot_reg, cross_reg;
    logic signed [50:0] pa_reg, pb_reg;
    logic signed [50:0] cx_reg, cy_reg;
    logic signed [27:0] cz_reg;
    logic [4:0] step_reg;
    logic [BOX_IDX_W:0] bi_reg;
    logic none_reg;
    // slab terms
    logic signed [26:0] xp_reg, xq_reg, yp_reg, yq_reg;
    logic [24:0] xa_reg, ya_reg;
    logic xall_reg, yall_reg;
    logic signed [52:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic rv_reg;
    cause_t rc_reg;

    assign res_valid = rv_reg;
    assign res_cause = rc_reg;
    assign q_ready   = (state_reg == ST_IDLE) && !rv_reg;

    logic [BOX_IDX_W-1:0] bidx;
    assign bidx = bi_reg[BOX_IDX_W-1:0];

    // slab setup from registered box
    logic signed [25:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [26:0] sp_x, sq_x, sp_y, sq_y;
    logic [24:0] sa_x, sa_y;
    logic sall_x, snone_x, sall_y, snone_y;

    always_comb begin
        lo_x = 26'(rl_reg);
        hi_x = 26'(rl_reg) + 26'(rw_reg);
        lo_y = 26'(rt_reg);
        hi_y = 26'(rt_reg) + 26'(rh_reg);
        sall_x = 1'b0; snone_x = 1'b0; sp_x = '0; sq_x = '0; sa_x = 25'd1;
        sall_y = 1'b0; snone_y = 1'b0; sp_y = '0; sq_y = '0; sa_y = 25'd1;
        if (lo_x > hi_x) begin
            snone_x = 1'b1;
        end else if (dx_reg == 0) begin
            if (26'(it_reg.ax) >= lo_x && 26'(it_reg.ax) <= hi_x) sall_x = 1'b1;
            else snone_x = 1'b1;
        end else if (dx_reg > 0) begin
            sp_x = 27'(lo_x) - 27'(it_reg.ax);
            sq_x = 27'(hi_x) - 27'(it_reg.ax);
            sa_x = 25'(dx_reg);
        end else begin
            sp_x = 27'(it_reg.ax) - 27'(hi_x);
            sq_x = 27'(it_reg.ax) - 27'(lo_x);
            sa_x = 25'(-dx_reg);
        end
        if (lo_y > hi_y) begin
            snone_y = 1'b1;
        end else if (dy_reg == 0) begin
            if (26'(it_reg.ay) >= lo_y && 26'(it_reg.ay) <= hi_y) sall_y = 1'b1;
            else snone_y = 1'b1;
        end else if (dy_reg > 0) begin
            sp_y = 27'(lo_y) - 27'(it_reg.ay);
            sq_y = 27'(hi_y) - 27'(it_reg.ay);
            sa_y = 25'(dy_reg);
        end else begin
            sp_y = 27'(it_reg.ay) - 27'(hi_y);
            sq_y = 27'(it_reg.ay) - 27'(lo_y);
            sa_y = 25'(-dy_reg);
        end
    end

    // early rejection from range checks
    logic rej_c;
    always_comb begin
        rej_c = none_reg;
        if (!xall_reg && (xq_reg < 0 || xp_reg > $signed({2'b0, xa_reg}))) rej_c = 1'b1;
        if (!yall_reg && (yq_reg < 0 || yp_reg > $signed({2'b0, ya_reg}))) rej_c = 1'b1;
    end

    // CORDIC step
    logic signed [50:0] fy, fx;
    logic signed [27:0] at;
    assign fy = cy_reg >>> step_reg;
    assign fx = cx_reg >>> step_reg;
    assign at = $signed({5'b0, atan_val(step_reg)});

    logic last_box;
    assign last_box = (bi_reg == (BOX_IDX_W+1)'(MAX_BOXES - 1));

    // Decisions shared by the state machine and the datapath.
    logic [50:0] d2_c;
    logic sense_c, far_c, cone_c, hit_c, norm_done;
    assign d2_c      = 51'(dx2_reg) + 51'(dy2_reg);
    assign sense_c   = (d2_c <= 51'(sr2_reg));
    assign far_c     = (d2_c > 51'(vr2_reg));
    assign cone_c    = (it_reg.va < 16'(FULL_ANGLE))
                       && (cz_reg > $signed({4'b0, it_reg.va, 8'b0}));
    assign hit_c     = !rej_c && (xall_reg || yall_reg
                                  || (m1_reg <= m2_reg && m3_reg <= m4_reg));
    // Both operands are non-negative here, so any bit from 46 up means >= 2^46.
    assign norm_done = (cx_reg[50:46] != 5'd0) || (cy_reg[50:46] != 5'd0)
                       || (cx_reg == 0 && cy_reg == 0);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (q_valid && q_ready && q_item.kind == KIND_QUERY)
                             state_next = ST_DIFF;
            ST_DIFF:     state_next = ST_SQ;
            ST_SQ:       state_next = ST_DIST;
            ST_DIST:     state_next = (sense_c || far_c) ? ST_DONE : ST_DOT;
            ST_DOT:      state_next = ST_ANG_PREP;
            ST_ANG_PREP: state_next = ST_NORM;
            ST_NORM:     if (norm_done)
                             state_next = ST_CORDIC;
            ST_CORDIC:   if (cy_reg == 0 || step_reg == 5'(CORDIC_STEPS - 1))
                             state_next = ST_ANG_CMP;
            ST_ANG_CMP:  state_next = cone_c ? ST_DONE : ST_BOX_RD;
            ST_BOX_RD:   state_next = ST_BOX_A;
            ST_BOX_A:    state_next = ST_BOX_B;
            ST_BOX_B:    state_next = ST_BOX_C;
            ST_BOX_C:    state_next = ST_BOX_D;
            ST_BOX_D:    state_next = (hit_c || last_box) ? ST_DONE : ST_BOX_RD;
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_valid && q_ready && q_item.kind == KIND_WRITE
            && 32'(q_item.slot) < MAX_BOXES) begin
            mem_l[BOX_IDX_W'(q_item.slot)] <= q_item.ax;
            mem_t[BOX_IDX_W'(q_item.slot)] <= q_item.ay;
            mem_w[BOX_IDX_W'(q_item.slot)] <= q_item.bx;
            mem_h[BOX_IDX_W'(q_item.slot)] <= q_item.by;
        end
        rl_reg <= mem_l[bidx];
        rt_reg <= mem_t[bidx];
        rw_reg <= mem_w[bidx];
        rh_reg <= mem_h[bidx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            rv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (rv_reg && res_ready) rv_reg <= 1'b0;
            if (q_valid && q_ready) begin
                unique case (q_item.kind)
                    KIND_WRITE:  if (32'(q_item.slot) < MAX_BOXES)
                                     valid_reg[BOX_IDX_W'(q_item.slot)] <= 1'b1;
                    KIND_REMOVE: if (32'(q_item.slot) < MAX_BOXES)
                                     valid_reg[BOX_IDX_W'(q_item.slot)] <= 1'b0;
                    KIND_CLEAR:  valid_reg <= '0;
                    KIND_QUERY:  ;
                    default:     ;
                endcase
            end
            if (state_reg == ST_DONE) rv_reg <= 1'b1;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                it_reg <= q_item;
            end
            ST_DIFF: begin
                dx_reg <= 25'(it_reg.bx) - 25'(it_reg.ax);
                dy_reg <= 25'(it_reg.by) - 25'(it_reg.ay);
            end
            ST_SQ: begin
                dx2_reg <= 50'(dx_reg * dx_reg);
                dy2_reg <= 50'(dy_reg * dy_reg);
                sr2_reg <= it_reg.sr * it_reg.sr;
                vr2_reg <= it_reg.vr * it_reg.vr;
                pa_reg  <= 51'(it_reg.vx * dx_reg);
                pb_reg  <= 51'(it_reg.vy * dy_reg);
                cx_reg  <= 51'(it_reg.vx * dy_reg);
                cy_reg  <= 51'(it_reg.vy * dx_reg);
            end
            ST_DIST: begin
                dot_reg   <= pa_reg + pb_reg;
                cross_reg <= cx_reg - cy_reg;
                if (sense_c) begin
                    rc_reg <= CAUSE_SENSE;
                end else if (far_c) begin
                    rc_reg <= CAUSE_FAR;
                end
            end
            ST_DOT: begin
                cross_reg <= (cross_reg < 0) ? -cross_reg : cross_reg;
            end
            ST_ANG_PREP: begin
                step_reg <= 5'd0;
                if (dot_reg < 0) begin
                    cx_reg <= cross_reg;
                    cy_reg <= -dot_reg;
                    cz_reg <= 28'sd5898240;
                end else begin
                    cx_reg <= dot_reg;
                    cy_reg <= cross_reg;
                    cz_reg <= '0;
                end
            end
            ST_NORM: begin
                if (!norm_done) begin
                    cx_reg <= cx_reg <<< 1;
                    cy_reg <= cy_reg <<< 1;
                end
            end
            ST_CORDIC: begin
                if (cy_reg != 0) begin
                    step_reg <= step_reg + 5'd1;
                    if (cy_reg > 0) begin
                        cx_reg <= cx_reg + fy;
                        cy_reg <= cy_reg - fx;
                        cz_reg <= cz_reg + at;
                    end else begin
                        cx_reg <= cx_reg - fy;
                        cy_reg <= cy_reg + fx;
                        cz_reg <= cz_reg - at;
                    end
                end
            end
            ST_ANG_CMP: begin
                bi_reg <= '0;
                if (cone_c) begin
                    rc_reg <= CAUSE_CONE;
                end else begin
                    rc_reg <= CAUSE_CLEAR;
                end
            end
            ST_BOX_RD: ;
            ST_BOX_A: begin
                none_reg <= snone_x || snone_y || !valid_reg[bidx];
                xall_reg <= sall_x; yall_reg <= sall_y;
                xp_reg <= sp_x; xq_reg <= sq_x; xa_reg <= sa_x;
                yp_reg <= sp_y; yq_reg <= sq_y; ya_reg <= sa_y;
            end
            ST_BOX_B: begin
                m1_reg <= 53'(xp_reg * $signed({1'b0, ya_reg}));
                m2_reg <= 53'(yq_reg * $signed({1'b0, xa_reg}));
            end
            ST_BOX_C: begin
                m3_reg <= 53'(yp_reg * $signed({1'b0, xa_reg}));
                m4_reg <= 53'(xq_reg * $signed({1'b0, ya_reg}));
            end
            ST_BOX_D: begin
                if (hit_c) begin
                    rc_reg <= CAUSE_BLOCKED;
                end
                bi_reg <= bi_reg + (BOX_IDX_W+1)'(1);
            end
            ST_DONE: ;
            default: ;
        endcase
    end

endmodule
